[rtl/tsg_pkg.sv]
// Package for the torus peer schedule generator.
// Holds sizes, register indexes, the controller state type, the command and
// status structs, and the ceiling-log2 helper. No dependencies.
package tsg_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int MAX_STEPS = 16;
  localparam int DIM_W     = $clog2(MAX_DIMS);
  localparam int STEP_W    = $clog2(MAX_STEPS);
  localparam int CNT_W     = STEP_W + 1;
  localparam int RANK_W    = 16;
  localparam int NODE_W    = 17;
  localparam int SIZE_W    = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = NODE_W;
  localparam int VIS_W     = 4;
  localparam int DIST_W    = 11;
  localparam int CO_W      = 12;
  localparam int DIV_STEPS = NODE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_INDEX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM3  = 3'd6;

  typedef enum logic [1:0] {
    OP_NN,
    OP_CO,
    OP_CM
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NN_GO,
    ST_NN_WAIT,
    ST_CO_GO,
    ST_CO_WAIT,
    ST_CM_GO,
    ST_CM_WAIT,
    ST_WGT,
    ST_STEP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    div_start;
    div_op_t div_op;
    logic    idx_inc;
    logic    wgt_init;
    logic    wgt_step;
    logic    step_go;
    logic    emit_go;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic idx_last;
    logic idx_zero;
    logic step_more;
    logic cnt_zero;
    logic emit_last;
  } sts_t;

  function automatic logic [4:0] clog2_node(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] m;
    logic [4:0]        k;
    m = n - NODE_W'(1);
    k = '0;
    if (n > NODE_W'(1)) begin
      for (int i = 0; i < NODE_W; i++) begin
        if (m[i]) k = 5'(i + 1);
      end
    end
    return k;
  endfunction

endpackage

[rtl/tsg_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Divide by zero gives quotient 0 and remainder equal to the dividend.
// Depends on tsg_pkg.
module tsg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tsg_pkg::NODE_W-1:0] dividend,
  input  logic [tsg_pkg::NODE_W-1:0] divisor,
  output logic                       done,
  output logic [tsg_pkg::NODE_W-1:0] quo,
  output logic [tsg_pkg::NODE_W-1:0] rem
);

  logic [tsg_pkg::NODE_W-1:0]    rem_r;
  logic [tsg_pkg::NODE_W-1:0]    quo_r;
  logic [tsg_pkg::NODE_W-1:0]    dvs_r;
  logic                          dz_r;
  logic [tsg_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          run_r;
  logic                          done_r;
  logic [tsg_pkg::NODE_W:0]      shl;
  logic [tsg_pkg::NODE_W+1:0]    diff;
  logic                          ge;

  assign shl  = {rem_r, quo_r[tsg_pkg::NODE_W-1]};
  assign diff = {1'b0, shl} - {2'b00, dvs_r};
  assign ge   = ~diff[tsg_pkg::NODE_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= tsg_pkg::DIV_CNT_W'(tsg_pkg::DIV_STEPS);
      end else if (run_r) begin
        cnt_r <= cnt_r - tsg_pkg::DIV_CNT_W'(1);
        if (cnt_r == tsg_pkg::DIV_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      dz_r  <= (divisor == '0);
    end else if (run_r) begin
      rem_r <= ge ? diff[tsg_pkg::NODE_W-1:0] : shl[tsg_pkg::NODE_W-1:0];
      quo_r <= {quo_r[tsg_pkg::NODE_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = dz_r ? '0 : quo_r;
  assign rem  = rem_r;

endmodule

[rtl/tsg_datapath.sv]
// Datapath: configuration registers, coordinate split through the divider,
// weight pass, per-step peer arithmetic, peer buffer and result registers.
// Depends on tsg_pkg and tsg_div.
module tsg_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [tsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsg_pkg::CFG_W-1:0]     cfg_data,
  input  logic [tsg_pkg::RANK_W-1:0]    in_node_rank,
  input  logic                          in_phase,
  input  tsg_pkg::cmd_t                 cmd,
  output tsg_pkg::sts_t                 sts,
  output logic                          out_valid,
  output logic [tsg_pkg::STEP_W-1:0]    out_step_index,
  output logic [tsg_pkg::RANK_W-1:0]    out_peer_rank,
  output logic                          out_last_step
);

  localparam int NDW = tsg_pkg::DIM_W + 1;

  logic [2:0]                  dim_count_r;
  logic [2:0]                  port_index_r;
  logic [tsg_pkg::NODE_W-1:0]  node_count_r;
  logic [tsg_pkg::SIZE_W-1:0]  size_r [tsg_pkg::MAX_DIMS];

  logic [NDW-1:0]              nd;
  logic                        mirrored;
  logic [tsg_pkg::CNT_W-1:0]   steps;
  logic [4:0]                  steps_raw;
  logic [tsg_pkg::VIS_W-1:0]   limit [tsg_pkg::MAX_DIMS];
  logic [tsg_pkg::DIM_W-1:0]   ptr_init;

  logic [tsg_pkg::NODE_W-1:0]  nn_r;
  logic [tsg_pkg::NODE_W-1:0]  id_r;
  logic [tsg_pkg::RANK_W-1:0]  coord_r [tsg_pkg::MAX_DIMS];
  logic [tsg_pkg::RANK_W-1:0]  cm_r [tsg_pkg::MAX_DIMS];
  logic [tsg_pkg::RANK_W-1:0]  w_r [tsg_pkg::MAX_DIMS];
  logic [tsg_pkg::RANK_W-1:0]  acc_r;
  logic [tsg_pkg::RANK_W-1:0]  base_r;
  logic [tsg_pkg::DIM_W-1:0]   idx_r;
  tsg_pkg::div_op_t            op_r;
  logic                        phase_r;
  logic [tsg_pkg::CNT_W-1:0]   cnt_r;
  logic [NDW-1:0]              live_r;
  logic [tsg_pkg::MAX_DIMS-1:0] done_r;
  logic [tsg_pkg::VIS_W-1:0]   visits_r [tsg_pkg::MAX_DIMS];
  logic signed [tsg_pkg::DIST_W-1:0] dist_r [tsg_pkg::MAX_DIMS];
  logic [tsg_pkg::DIM_W-1:0]   ptr_r;
  logic [tsg_pkg::STEP_W-1:0]  k_r;
  logic [tsg_pkg::RANK_W-1:0]  peers_r [tsg_pkg::MAX_STEPS];

  logic                        out_valid_r;
  logic [tsg_pkg::STEP_W-1:0]  out_step_r;
  logic [tsg_pkg::RANK_W-1:0]  out_peer_r;
  logic                        out_last_r;

  logic [tsg_pkg::NODE_W-1:0]  div_a;
  logic [tsg_pkg::NODE_W-1:0]  div_b;
  logic                        div_done;
  logic [tsg_pkg::NODE_W-1:0]  div_q;
  logic [tsg_pkg::NODE_W-1:0]  div_rm;

  logic [tsg_pkg::DIM_W-1:0]   td;
  logic                        used_up;
  logic signed [tsg_pkg::DIST_W-1:0] dcur;
  logic signed [tsg_pkg::DIST_W-1:0] dd;
  logic signed [tsg_pkg::CO_W-1:0] s_td;
  logic signed [tsg_pkg::CO_W-1:0] cm_td;
  logic signed [tsg_pkg::CO_W-1:0] csum;
  logic signed [tsg_pkg::CO_W-1:0] cfix;
  logic signed [tsg_pkg::CO_W-1:0] delta;
  logic [tsg_pkg::RANK_W-1:0]  dext;
  logic [2*tsg_pkg::RANK_W-1:0] dprod;
  logic [tsg_pkg::RANK_W-1:0]  peer;
  logic [tsg_pkg::DIM_W-1:0]   ptr_nxt;
  logic [2*tsg_pkg::RANK_W-1:0] base_prod;
  logic [2*tsg_pkg::RANK_W-1:0] acc_prod;
  logic [tsg_pkg::STEP_W-1:0]  ridx;
  logic                        emit_last;

  // Effective configuration
  always_comb begin
    logic [2:0] v;
    if (dim_count_r == 3'd0) begin
      nd = NDW'(1);
    end else if (dim_count_r > 3'(tsg_pkg::MAX_DIMS)) begin
      nd = NDW'(tsg_pkg::MAX_DIMS);
    end else begin
      nd = NDW'(dim_count_r);
    end
    mirrored  = ({2'b00, port_index_r} >= 5'(nd));
    steps_raw = tsg_pkg::clog2_node(node_count_r);
    steps     = (steps_raw > 5'(tsg_pkg::MAX_STEPS)) ? tsg_pkg::CNT_W'(tsg_pkg::MAX_STEPS)
                                                     : tsg_pkg::CNT_W'(steps_raw);
    for (int i = 0; i < tsg_pkg::MAX_DIMS; i++) begin
      limit[i] = tsg_pkg::VIS_W'(tsg_pkg::clog2_node({8'd0, size_r[i]}));
    end
    v = port_index_r;
    for (int i = 0; i < 7; i++) begin
      if ({2'b00, v} >= 5'(nd)) v = 3'(v - 3'(nd));
    end
    ptr_init = tsg_pkg::DIM_W'(v);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r  <= 3'd1;
      port_index_r <= 3'd0;
      node_count_r <= tsg_pkg::NODE_W'(1);
      for (int i = 0; i < tsg_pkg::MAX_DIMS; i++) begin
        size_r[i] <= tsg_pkg::SIZE_W'(1);
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        tsg_pkg::CFG_DIM_COUNT:  dim_count_r  <= cfg_data[2:0];
        tsg_pkg::CFG_PORT_INDEX: port_index_r <= cfg_data[2:0];
        tsg_pkg::CFG_NODE_COUNT: node_count_r <= cfg_data;
        tsg_pkg::CFG_SIZE_DIM0:  size_r[0]    <= cfg_data[tsg_pkg::SIZE_W-1:0];
        tsg_pkg::CFG_SIZE_DIM1:  size_r[1]    <= cfg_data[tsg_pkg::SIZE_W-1:0];
        tsg_pkg::CFG_SIZE_DIM2:  size_r[2]    <= cfg_data[tsg_pkg::SIZE_W-1:0];
        tsg_pkg::CFG_SIZE_DIM3:  size_r[3]    <= cfg_data[tsg_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider operands
  always_comb begin
    case (cmd.div_op)
      tsg_pkg::OP_NN: begin
        div_a = nn_r;
        div_b = tsg_pkg::NODE_W'(size_r[idx_r]);
      end
      tsg_pkg::OP_CO: begin
        div_a = id_r;
        div_b = nn_r;
      end
      tsg_pkg::OP_CM: begin
        div_a = tsg_pkg::NODE_W'(coord_r[idx_r]);
        div_b = tsg_pkg::NODE_W'(size_r[idx_r]);
      end
      default: begin
        div_a = nn_r;
        div_b = nn_r;
      end
    endcase
  end

  tsg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_rm)
  );

  // Step arithmetic
  always_comb begin
    logic [NDW:0] cand;
    logic         found;
    td    = '0;
    found = 1'b0;
    for (int o = 0; o < tsg_pkg::MAX_DIMS; o++) begin
      cand = (NDW+1)'(ptr_r) + (NDW+1)'(o);
      if (cand >= (NDW+1)'(nd)) cand = cand - (NDW+1)'(nd);
      if ((NDW'(o) < nd) && !found && !done_r[cand[tsg_pkg::DIM_W-1:0]]) begin
        td    = cand[tsg_pkg::DIM_W-1:0];
        found = 1'b1;
      end
    end
    used_up = (visits_r[td] >= limit[td]);
    dcur    = dist_r[td];
    dd      = (coord_r[td][0] ^ mirrored) ? -dcur : dcur;
    s_td    = signed'(tsg_pkg::CO_W'(size_r[td]));
    cm_td   = signed'(tsg_pkg::CO_W'(cm_r[td][tsg_pkg::SIZE_W-1:0]));
    csum    = cm_td + tsg_pkg::CO_W'(dd);
    if (csum < 0) begin
      cfix = csum + s_td;
    end else if (csum >= s_td) begin
      cfix = csum - s_td;
    end else begin
      cfix = csum;
    end
    delta = cfix - cm_td;
    dext  = tsg_pkg::RANK_W'(delta);
    dprod = dext * w_r[td];
    peer  = base_r + dprod[tsg_pkg::RANK_W-1:0];
    if ((NDW'(ptr_r) + NDW'(1)) >= nd) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_r + tsg_pkg::DIM_W'(1);
    end
  end

  assign base_prod = cm_r[idx_r] * acc_r;
  assign acc_prod  = acc_r * tsg_pkg::RANK_W'(size_r[idx_r]);

  assign ridx      = phase_r ? (cnt_r[tsg_pkg::STEP_W-1:0] - tsg_pkg::STEP_W'(1) - k_r) : k_r;
  assign emit_last = ((tsg_pkg::CNT_W'(k_r) + tsg_pkg::CNT_W'(1)) == cnt_r);

  // Control registers of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      live_r      <= '0;
      done_r      <= '0;
      idx_r       <= '0;
      ptr_r       <= '0;
      k_r         <= '0;
      op_r        <= tsg_pkg::OP_NN;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_go;
      if (cmd.load) begin
        cnt_r  <= '0;
        live_r <= nd;
        done_r <= '0;
        idx_r  <= '0;
        ptr_r  <= ptr_init;
        k_r    <= '0;
      end
      if (cmd.div_start) op_r <= cmd.div_op;
      if (cmd.idx_inc) idx_r <= idx_r + tsg_pkg::DIM_W'(1);
      if (cmd.wgt_step) idx_r <= idx_r - tsg_pkg::DIM_W'(1);
      if (cmd.step_go) begin
        if (used_up) begin
          done_r[td] <= 1'b1;
          live_r     <= live_r - NDW'(1);
        end else begin
          cnt_r <= cnt_r + tsg_pkg::CNT_W'(1);
          ptr_r <= ptr_nxt;
        end
      end
      if (cmd.emit_go) k_r <= k_r + tsg_pkg::STEP_W'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nn_r    <= node_count_r;
      id_r    <= tsg_pkg::NODE_W'(in_node_rank);
      phase_r <= in_phase;
      for (int i = 0; i < tsg_pkg::MAX_DIMS; i++) begin
        visits_r[i] <= '0;
        dist_r[i]   <= tsg_pkg::DIST_W'(1);
      end
    end
    if (div_done) begin
      case (op_r)
        tsg_pkg::OP_NN: nn_r <= div_q;
        tsg_pkg::OP_CO: begin
          coord_r[idx_r] <= div_q[tsg_pkg::RANK_W-1:0];
          id_r           <= div_rm;
        end
        tsg_pkg::OP_CM: cm_r[idx_r] <= div_rm[tsg_pkg::RANK_W-1:0];
        default: ;
      endcase
    end
    if (cmd.wgt_init) begin
      acc_r  <= tsg_pkg::RANK_W'(1);
      base_r <= '0;
    end
    if (cmd.wgt_step) begin
      w_r[idx_r] <= acc_r;
      base_r     <= base_r + base_prod[tsg_pkg::RANK_W-1:0];
      acc_r      <= acc_prod[tsg_pkg::RANK_W-1:0];
    end
    if (cmd.step_go && !used_up) begin
      dist_r[td]   <= tsg_pkg::DIST_W'(1) - (dcur <<< 1);
      visits_r[td] <= visits_r[td] + tsg_pkg::VIS_W'(1);
      peers_r[cnt_r[tsg_pkg::STEP_W-1:0]] <= peer;
    end
    if (cmd.emit_go) begin
      out_step_r <= k_r;
      out_peer_r <= peers_r[ridx];
      out_last_r <= emit_last;
    end
  end

  assign sts.div_done  = div_done;
  assign sts.idx_last  = (NDW'(idx_r) == (nd - NDW'(1)));
  assign sts.idx_zero  = (idx_r == '0);
  assign sts.step_more = (cnt_r < steps) && (live_r != '0);
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.emit_last = emit_last;

  assign out_valid      = out_valid_r;
  assign out_step_index = out_step_r;
  assign out_peer_rank  = out_peer_r;
  assign out_last_step  = out_last_r;

endmodule

[rtl/tsg_ctrl.sv]
// Controller state machine: sequences the coordinate split, weight pass,
// step walk and result emission. Depends on tsg_pkg.
module tsg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  tsg_pkg::sts_t sts,
  output tsg_pkg::cmd_t cmd,
  output logic          busy
);

  tsg_pkg::state_t state_r;
  tsg_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsg_pkg::ST_IDLE:    if (start) state_nxt = tsg_pkg::ST_NN_GO;
      tsg_pkg::ST_NN_GO:   state_nxt = tsg_pkg::ST_NN_WAIT;
      tsg_pkg::ST_NN_WAIT: if (sts.div_done) state_nxt = tsg_pkg::ST_CO_GO;
      tsg_pkg::ST_CO_GO:   state_nxt = tsg_pkg::ST_CO_WAIT;
      tsg_pkg::ST_CO_WAIT: if (sts.div_done) state_nxt = tsg_pkg::ST_CM_GO;
      tsg_pkg::ST_CM_GO:   state_nxt = tsg_pkg::ST_CM_WAIT;
      tsg_pkg::ST_CM_WAIT: begin
        if (sts.div_done) begin
          state_nxt = sts.idx_last ? tsg_pkg::ST_WGT : tsg_pkg::ST_NN_GO;
        end
      end
      tsg_pkg::ST_WGT:     if (sts.idx_zero) state_nxt = tsg_pkg::ST_STEP;
      tsg_pkg::ST_STEP: begin
        if (!sts.step_more) begin
          state_nxt = sts.cnt_zero ? tsg_pkg::ST_IDLE : tsg_pkg::ST_EMIT;
        end
      end
      tsg_pkg::ST_EMIT:    if (sts.emit_last) state_nxt = tsg_pkg::ST_IDLE;
      default:             state_nxt = tsg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.div_op = tsg_pkg::OP_NN;
    case (state_r)
      tsg_pkg::ST_IDLE:  cmd.load = start;
      tsg_pkg::ST_NN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = tsg_pkg::OP_NN;
      end
      tsg_pkg::ST_CO_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = tsg_pkg::OP_CO;
      end
      tsg_pkg::ST_CM_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = tsg_pkg::OP_CM;
      end
      tsg_pkg::ST_CM_WAIT: begin
        cmd.wgt_init = sts.div_done & sts.idx_last;
        cmd.idx_inc  = sts.div_done & ~sts.idx_last;
      end
      tsg_pkg::ST_WGT:   cmd.wgt_step = 1'b1;
      tsg_pkg::ST_STEP:  cmd.step_go  = sts.step_more;
      tsg_pkg::ST_EMIT:  cmd.emit_go  = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state_r != tsg_pkg::ST_IDLE);

endmodule

[rtl/torus_peer_schedule_generator.sv]
// Torus peer schedule generator, top level: controller plus datapath.
// Depends on tsg_pkg, tsg_ctrl, tsg_datapath (with tsg_div).
//
// A request (rank and phase) is taken when start is high and busy is low.
// The rank is split into torus coordinates by a bit-serial divider: three
// divisions per dimension in use (launch, 17 quotient bits, finish). A
// weight pass then covers each dimension in turn, and the step walk records
// one step or retires one used-up dimension at a time. The results follow
// one per cycle, each shown on out_valid for a single cycle; the receiver
// cannot stall them, so it must take every word as it appears. The last
// word shows in the same cycle in which busy falls. Configuration is written
// through cfg_valid/cfg_ready; cfg_ready is high only while busy is low.
module torus_peer_schedule_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tsg_pkg::RANK_W-1:0]    in_node_rank,
  input  logic                          in_phase,
  output logic                          out_valid,
  output logic [tsg_pkg::STEP_W-1:0]    out_step_index,
  output logic [tsg_pkg::RANK_W-1:0]    out_peer_rank,
  output logic                          out_last_step,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsg_pkg::CFG_W-1:0]     cfg_data
);

  tsg_pkg::cmd_t cmd;
  tsg_pkg::sts_t sts;
  logic          busy_int;

  assign cfg_ready = ~busy_int;
  assign busy      = busy_int;

  tsg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy_int)
  );

  tsg_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid & ~busy_int),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_node_rank   (in_node_rank),
    .in_phase       (in_phase),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_step_index (out_step_index),
    .out_peer_rank  (out_peer_rank),
    .out_last_step  (out_last_step)
  );

endmodule

[dv/torus_peer_schedule_generator_tb.sv]
// Self-checking testbench for torus_peer_schedule_generator.
// Depends on tsg_pkg and the RTL. It predicts each peer sequence from the
// configuration and checks every output word against the prediction.
module torus_peer_schedule_generator_tb;

  typedef struct {
    logic [tsg_pkg::STEP_W-1:0] step;
    logic [tsg_pkg::RANK_W-1:0] peer;
    logic                       last;
  } peer_word_t;

  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT  = 5000;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [tsg_pkg::RANK_W-1:0]    in_node_rank;
  logic                          in_phase;
  logic                          out_valid;
  logic [tsg_pkg::STEP_W-1:0]    out_step_index;
  logic [tsg_pkg::RANK_W-1:0]    out_peer_rank;
  logic                          out_last_step;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [tsg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tsg_pkg::CFG_W-1:0]     cfg_data;

  logic [2:0]  m_dim_count;
  logic [2:0]  m_port_index;
  logic [16:0] m_node_count;
  logic [8:0]  m_size[tsg_pkg::MAX_DIMS];

  peer_word_t peer_queue[$];
  int         errors;
  int         items_sent;
  int         words_seen;
  int         cfg_writes;
  int         stall_cycles;

  torus_peer_schedule_generator u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_node_rank(in_node_rank), .in_phase(in_phase),
    .out_valid(out_valid), .out_step_index(out_step_index),
    .out_peer_rank(out_peer_rank), .out_last_step(out_last_step),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned ceil_log2(int unsigned n);
    int unsigned k;
    k = 0;
    if (n <= 1) return 0;
    while (k < 31 && (32'd1 << k) < n) k++;
    return k;
  endfunction

  function automatic void predict_peers(logic [tsg_pkg::RANK_W-1:0] rank, logic phase);
    int unsigned nd, steps, count, live, id, nn, o, td, cv;
    int unsigned coord[tsg_pkg::MAX_DIMS];
    int unsigned lim[tsg_pkg::MAX_DIMS];
    int unsigned visits[tsg_pkg::MAX_DIMS];
    int          dstep[tsg_pkg::MAX_DIMS];
    bit          done[tsg_pkg::MAX_DIMS];
    bit [31:0]   peers[tsg_pkg::MAX_STEPS];
    bit [31:0]   r, mult;
    bit          mirrored;
    int          d, c, s;
    peer_word_t  w;
    nd = m_dim_count;
    if (nd < 1) nd = 1;
    if (nd > tsg_pkg::MAX_DIMS) nd = tsg_pkg::MAX_DIMS;
    mirrored = m_port_index >= nd;
    steps = ceil_log2(m_node_count);
    if (steps > tsg_pkg::MAX_STEPS) steps = tsg_pkg::MAX_STEPS;
    id = rank;
    nn = m_node_count;
    count = 0;
    live = 0;
    for (int i = 0; i < nd; i++) begin
      nn = (m_size[i] != 0) ? nn / m_size[i] : 0;
      coord[i] = (nn != 0) ? id / nn : 0;
      id = (nn != 0) ? id % nn : id;
      lim[i] = ceil_log2(m_size[i]);
      visits[i] = 0;
      dstep[i] = 1;
      done[i] = 1'b0;
      live++;
    end
    while (count < steps && live > 0) begin
      o = 0;
      do begin
        td = (m_port_index + count + o) % nd;
        o++;
      end while (done[td]);
      if (visits[td] >= lim[td]) begin
        done[td] = 1'b1;
        live--;
      end else begin
        d = dstep[td];
        dstep[td] = 1 - 2 * dstep[td];
        visits[td]++;
        if (coord[td] & 1) d = -d;
        if (mirrored) d = -d;
        s = m_size[td];
        c = (int'(coord[td]) + d) % s;
        if (c < 0) c += s;
        r = 0;
        mult = 1;
        for (int j = nd - 1; j >= 0; j--) begin
          cv = (j == td) ? c : coord[j];
          if (m_size[j] != 0 && cv >= m_size[j]) cv = cv % m_size[j];
          r = r + mult * cv;
          mult = mult * m_size[j];
        end
        peers[count] = r;
        count++;
      end
    end
    for (int k = 0; k < count; k++) begin
      w.step = k[tsg_pkg::STEP_W-1:0];
      w.peer = phase ? peers[count - 1 - k][15:0] : peers[k][15:0];
      w.last = (k + 1 == count);
      peer_queue.insert(peer_queue.size(), w);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    peer_word_t w;
    if (rst_n && out_valid) begin
      words_seen++;
      if (peer_queue.size() == 0) begin
        report_mismatch("unexpected word, step", out_step_index, -1);
      end else begin
        w = peer_queue.pop_front();
        if (out_step_index !== w.step) report_mismatch("step_index", out_step_index, w.step);
        if (out_peer_rank !== w.peer) report_mismatch("peer_rank", out_peer_rank, w.peer);
        if (out_last_step !== w.last) report_mismatch("last_step", out_last_step, w.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress in %0d cycles", STALL_LIMIT);
        $display("FAIL torus_peer_schedule_generator");
        $finish;
      end
    end
  end

  task automatic send_request(logic [tsg_pkg::RANK_W-1:0] rank, logic phase);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk);
    @(posedge clk);
    start        <= 1'b1;
    in_node_rank <= rank;
    in_phase     <= phase;
    do @(posedge clk); while (busy);
    predict_peers(rank, phase);
    items_sent++;
    start <= 1'b0;
  endtask

  task automatic wait_drain();
    while (peer_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [tsg_pkg::CFG_IDX_W-1:0] idx,
                           logic [tsg_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tsg_pkg::CFG_DIM_COUNT:  m_dim_count  = data[2:0];
      tsg_pkg::CFG_PORT_INDEX: m_port_index = data[2:0];
      tsg_pkg::CFG_NODE_COUNT: m_node_count = data[16:0];
      tsg_pkg::CFG_SIZE_DIM0:  m_size[0]    = data[8:0];
      tsg_pkg::CFG_SIZE_DIM1:  m_size[1]    = data[8:0];
      tsg_pkg::CFG_SIZE_DIM2:  m_size[2]    = data[8:0];
      tsg_pkg::CFG_SIZE_DIM3:  m_size[3]    = data[8:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_torus(int dims, int port, int nodes, int s0, int s1, int s2, int s3);
    wait_drain();
    write_reg(tsg_pkg::CFG_DIM_COUNT, tsg_pkg::CFG_W'(dims));
    write_reg(tsg_pkg::CFG_PORT_INDEX, tsg_pkg::CFG_W'(port));
    write_reg(tsg_pkg::CFG_NODE_COUNT, tsg_pkg::CFG_W'(nodes));
    write_reg(tsg_pkg::CFG_SIZE_DIM0, tsg_pkg::CFG_W'(s0));
    write_reg(tsg_pkg::CFG_SIZE_DIM1, tsg_pkg::CFG_W'(s1));
    write_reg(tsg_pkg::CFG_SIZE_DIM2, tsg_pkg::CFG_W'(s2));
    write_reg(tsg_pkg::CFG_SIZE_DIM3, tsg_pkg::CFG_W'(s3));
  endtask

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1);
      1:       return $urandom_range(0, 511);
      2:       return 256;
      default: return $urandom_range(2, 16);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_request(16'h0000, 1'b0);
    send_request(16'hFFFF, 1'b1);
  endtask

  task automatic test_extremes();
    set_torus(4, 0, 65536, 16, 16, 16, 16);
    send_request(16'h0000, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h5A5A, 1'b1);
    set_torus(2, 1, 65536, 256, 256, 256, 256);
    send_request(16'h0000, 1'b0);
    send_request(16'hFFFF, 1'b1);
    set_torus(1, 0, 256, 256, 1, 1, 1);
    send_request(16'd255, 1'b0);
    send_request(16'd128, 1'b1);
    set_torus(0, 7, 131071, 511, 0, 0, 0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h1234, 1'b1);
  endtask

  task automatic test_mirror_and_early_end();
    set_torus(3, 5, 8, 2, 2, 2, 1);
    for (int r = 0; r < 8; r++) send_request(tsg_pkg::RANK_W'(r), r[0]);
    set_torus(7, 4, 4096, 1, 3, 0, 5);
    send_request(16'd7, 1'b0);
    send_request(16'd100, 1'b1);
    set_torus(2, 2, 2, 1, 1, 1, 1);
    send_request(16'd1, 1'b0);
  endtask

  task automatic test_random_schedules();
    int dims, s[tsg_pkg::MAX_DIMS], prod, nodes, phase_items;
    logic [tsg_pkg::RANK_W-1:0] rank;
    for (int ph = 0; ph < 20; ph++) begin
      dims = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      prod = 1;
      for (int i = 0; i < tsg_pkg::MAX_DIMS; i++) begin
        s[i] = pick_size();
        if (i < dims) prod = prod * s[i];
        if (prod > 131071) prod = 131071;
      end
      nodes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071) : prod;
      if (nodes > 131071) nodes = 131071;
      set_torus(dims, $urandom_range(0, 7), nodes, s[0], s[1], s[2], s[3]);
      phase_items = 25;
      for (int k = 0; k < phase_items; k++) begin
        if ($urandom_range(0, 4) == 0 || nodes == 0) rank = tsg_pkg::RANK_W'($urandom);
        else rank = tsg_pkg::RANK_W'($urandom_range(0, nodes - 1));
        send_request(rank, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_node_rank = '0;
    in_phase     = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    errors       = 0;
    items_sent   = 0;
    words_seen   = 0;
    cfg_writes   = 0;
    stall_cycles = 0;
    m_dim_count  = 3'd1;
    m_port_index = 3'd0;
    m_node_count = 17'd1;
    for (int i = 0; i < tsg_pkg::MAX_DIMS; i++) m_size[i] = 9'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_extremes();
    test_mirror_and_early_end();
    test_random_schedules();
    wait_drain();
    $display("covered %0d requests, %0d peer words, %0d register writes",
             items_sent, words_seen, cfg_writes);
    if (errors == 0) begin
      $display("PASS torus_peer_schedule_generator");
    end else begin
      $display("FAIL torus_peer_schedule_generator");
    end
    $finish;
  end

endmodule
